/* rtl/afc_pkg.sv */
// ============================================================================
// afc_pkg: shared types and constants for the AABB frustum cull block
// Field widths, plane table and configuration register codes.
// ============================================================================
package afc_pkg;

    // Plane and matrix geometry
    localparam int PLANE_COUNT = 6;
    localparam int ROW_COUNT   = 4;
    localparam int ENTRY_W     = 16;   // signed Q4.12
    localparam int ROW_W       = ROW_COUNT * ENTRY_W;
    localparam int COMP_W      = ENTRY_W + 1;        // signed Q5.12
    localparam int COORD_W     = 24;   // signed Q16.8
    localparam int PROD_W      = COMP_W + COORD_W;   // signed Q21.20
    localparam int ACC_W       = PROD_W + 3;
    localparam int TERM_SHIFT  = 8;    // align the Q.12 constant term to Q.20
    localparam int CFG_ADDR_W  = 3;

    typedef logic signed [ENTRY_W-1:0] entry_t;
    typedef logic signed [COMP_W-1:0]  comp_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic [ROW_W-1:0]          row_t;
    typedef logic [CFG_ADDR_W-1:0]     cfg_addr_t;

    // Configuration register codes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROW_ZERO  = 3'd0,
        REG_ROW_ONE   = 3'd1,
        REG_ROW_TWO   = 3'd2,
        REG_ROW_THREE = 3'd3
    } cfg_reg_t;

    // One plane: normal components x, y, z and constant term w
    typedef struct packed {
        comp_t w;
        comp_t z;
        comp_t y;
        comp_t x;
    } plane_t;

    // One box as carried down the pipeline
    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
    } box_t;

    // Per-stage load enables handed to each plane lane
    typedef struct packed {
        logic sel;
        logic mul;
        logic sum;
    } stage_en_t;

    // Plane order: left, right, top, bottom, near, far
    localparam logic [1:0] PLANE_ROW [PLANE_COUNT] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
    localparam logic       PLANE_SUB [PLANE_COUNT] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    // Signed entry c of a matrix row
    function automatic entry_t row_entry(input row_t row, input int unsigned c);
        return entry_t'(row[ENTRY_W*c +: ENTRY_W]);
    endfunction

endpackage

/* rtl/afc_box_if.sv */
// ============================================================================
// afc_box_if: box input channel
// Valid/ready handshake carrying the six box coordinates.
// ============================================================================
interface afc_box_if;
    import afc_pkg::*;

    logic   valid;
    logic   ready;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

/* rtl/afc_vis_if.sv */
// ============================================================================
// afc_vis_if: result channel
// Valid/ready handshake carrying the visibility flag of one box.
// ============================================================================
interface afc_vis_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (
        output valid, visible,
        input  ready
    );
    modport sink (
        input  valid, visible,
        output ready
    );
endinterface

/* rtl/afc_cfg_if.sv */
// ============================================================================
// afc_cfg_if: configuration write channel
// Valid/ready handshake carrying a register index and 64-bit write data.
// ============================================================================
interface afc_cfg_if;
    import afc_pkg::*;

    logic      valid;
    logic      ready;
    cfg_addr_t addr;
    row_t      data;

    modport source (
        output valid, addr, data,
        input  ready
    );
    modport sink (
        input  valid, addr, data,
        output ready
    );
endinterface

/* rtl/afc_plane_gen.sv */
// ============================================================================
// afc_plane_gen: matrix row registers and plane set-up
// Holds the four view-projection rows and registers the six planes formed
// from row 3 plus or minus rows 0, 1 and 2.
// ============================================================================
module afc_plane_gen (
    input  logic            clk,
    input  logic            rst_n,
    afc_cfg_if.sink         cfg,
    output afc_pkg::plane_t planes [afc_pkg::PLANE_COUNT]
);
    import afc_pkg::*;

    row_t   row_reg   [ROW_COUNT];
    plane_t plane_reg [PLANE_COUNT];
    plane_t plane_next [PLANE_COUNT];

    // Always take configuration transfers
    assign cfg.ready = 1'b1;

    // Write the addressed row; drop writes beyond the last row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROW_COUNT; r++)
            begin
                row_reg[r] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                REG_ROW_ZERO:  row_reg[0] <= cfg.data;
                REG_ROW_ONE:   row_reg[1] <= cfg.data;
                REG_ROW_TWO:   row_reg[2] <= cfg.data;
                REG_ROW_THREE: row_reg[3] <= cfg.data;
                default:       ;
            endcase
        end
    end

    // Form each plane as row 3 plus or minus its partner row
    always_comb
    begin
        comp_t comp [ROW_COUNT];
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            for (int c = 0; c < ROW_COUNT; c++)
            begin
                if (PLANE_SUB[p])
                begin
                    comp[c] = comp_t'(row_entry(row_reg[3], c))
                            - comp_t'(row_entry(row_reg[PLANE_ROW[p]], c));
                end
                else
                begin
                    comp[c] = comp_t'(row_entry(row_reg[3], c))
                            + comp_t'(row_entry(row_reg[PLANE_ROW[p]], c));
                end
            end
            plane_next[p].x = comp[0];
            plane_next[p].y = comp[1];
            plane_next[p].z = comp[2];
            plane_next[p].w = comp[3];
        end
    end

    // Hold the planes in registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                plane_reg[p] <= '0;
            end
        end
        else
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                plane_reg[p] <= plane_next[p];
            end
        end
    end

    assign planes = plane_reg;

endmodule

/* rtl/afc_plane_lane.sv */
// ============================================================================
// afc_plane_lane: positive-vertex test against one plane
// Three stages: corner select, multiply, sum and sign. Flags a box that
// lies wholly on the outer side of the plane.
// ============================================================================
module afc_plane_lane (
    input  logic               clk,
    input  afc_pkg::stage_en_t en,
    input  afc_pkg::plane_t    plane,
    input  afc_pkg::box_t      box,
    output logic               outside
);
    import afc_pkg::*;

    coord_t sel_x_reg, sel_y_reg, sel_z_reg;
    prod_t  prod_x_reg, prod_y_reg, prod_z_reg;
    logic   outside_reg;
    acc_t   acc_next;

    // Pick the corner farthest along the normal: max where the component is positive
    always_ff @(posedge clk)
    begin
        if (en.sel)
        begin
            sel_x_reg <= (plane.x > comp_t'(0)) ? box.max_x : box.min_x;
            sel_y_reg <= (plane.y > comp_t'(0)) ? box.max_y : box.min_y;
            sel_z_reg <= (plane.z > comp_t'(0)) ? box.max_z : box.min_z;
        end
    end

    // Multiply each component by its chosen coordinate
    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            prod_x_reg <= prod_t'(plane.x) * prod_t'(sel_x_reg);
            prod_y_reg <= prod_t'(plane.y) * prod_t'(sel_y_reg);
            prod_z_reg <= prod_t'(plane.z) * prod_t'(sel_z_reg);
        end
    end

    // Add the scaled constant term and keep the sign
    assign acc_next = acc_t'(prod_x_reg) + acc_t'(prod_y_reg) + acc_t'(prod_z_reg)
                    + (acc_t'(plane.w) <<< TERM_SHIFT);

    always_ff @(posedge clk)
    begin
        if (en.sum)
        begin
            outside_reg <= acc_next[ACC_W-1];
        end
    end

    assign outside = outside_reg;

endmodule

/* rtl/aabb_frustum_cull.sv */
// Throughput: one box per cycle while vis is ready; each of the six plane lanes has its own three
//   multipliers, so no unit is shared between boxes.
// Each stage stalls only while full and blocked downstream; empty stages keep filling.
// Reset: asynchronous, active low; clears the pipeline valid bits and the matrix
//   rows, so all planes are zero and every box is visible until rows are written.
// ============================================================================
// aabb_frustum_cull: view-frustum test for axis-aligned boxes
// Stage 0 registers the box, the plane lanes select, multiply and sum, and the
// output stage combines the six plane flags into the visibility result.
// ============================================================================
module aabb_frustum_cull (
    input  logic    clk,
    input  logic    rst_n,
    afc_box_if.sink box,
    afc_vis_if.source vis,
    afc_cfg_if.sink cfg
);
    import afc_pkg::*;

    plane_t               planes [PLANE_COUNT];
    stage_en_t            en;
    logic                 en_in, en_out;
    logic                 v_in_reg, v_sel_reg, v_mul_reg, v_sum_reg, out_valid_reg;
    box_t                 box_reg;
    logic [PLANE_COUNT-1:0] outside;
    logic                 visible_reg;

    // Matrix rows and plane set-up
    afc_plane_gen u_plane_gen (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .planes (planes)
    );

    // Advance a stage when it is empty or the next one advances
    assign en_out  = !out_valid_reg || vis.ready;
    assign en.sum  = !v_sum_reg || en_out;
    assign en.mul  = !v_mul_reg || en.sum;
    assign en.sel  = !v_sel_reg || en.mul;
    assign en_in   = !v_in_reg  || en.sel;
    assign box.ready = en_in;

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg      <= 1'b0;
            v_sel_reg     <= 1'b0;
            v_mul_reg     <= 1'b0;
            v_sum_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_in)
            begin
                v_in_reg <= box.valid;
            end
            if (en.sel)
            begin
                v_sel_reg <= v_in_reg;
            end
            if (en.mul)
            begin
                v_mul_reg <= v_sel_reg;
            end
            if (en.sum)
            begin
                v_sum_reg <= v_mul_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= v_sum_reg;
            end
        end
    end

    // Capture the box on transfer
    always_ff @(posedge clk)
    begin
        if (en_in)
        begin
            box_reg.min_x <= box.box_min_x;
            box_reg.min_y <= box.box_min_y;
            box_reg.min_z <= box.box_min_z;
            box_reg.max_x <= box.box_max_x;
            box_reg.max_y <= box.box_max_y;
            box_reg.max_z <= box.box_max_z;
        end
    end

    // One lane per plane
    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_lane
        afc_plane_lane u_lane (
            .clk     (clk),
            .en      (en),
            .plane   (planes[p]),
            .box     (box_reg),
            .outside (outside[p])
        );
    end

    // Visible only when no plane rejects the box
    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            visible_reg <= ~|outside;
        end
    end

    assign vis.valid   = out_valid_reg;
    assign vis.visible = visible_reg;

    // A transfer always lands in stage 0
    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        box.valid && box.ready |=> v_in_reg)
        else $error("accepted box not held in stage 0");

    // Input is refused only while every stage holds a box
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !box.ready |-> v_in_reg && v_sel_reg && v_mul_reg && v_sum_reg && out_valid_reg)
        else $error("input stalled with a free slot in the pipeline");

    // A stalled sum stage keeps its item
    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_sum_reg && !en.sum |=> v_sum_reg && $stable(outside))
        else $error("stalled sum stage lost or changed its item");

    // A moving multiply stage hands its item on
    a_mul_advance: assert property (@(posedge clk) disable iff (!rst_n)
        v_mul_reg && en.sum |=> v_sum_reg)
        else $error("item lost between multiply and sum stages");

endmodule
